// ===== src/footstep_successor_pose_defines.svh =====
// Assertion macros shared by the footstep successor block.
`ifndef FOOTSTEP_SUCCESSOR_POSE_DEFINES_SVH
`define FOOTSTEP_SUCCESSOR_POSE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define FSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fsp assertion failed");

// Condition that must hold in the cycle after reset is sampled asserted.
`define FSP_ASSERT_AFTER_RST(lbl, cons) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("fsp reset assertion failed");

`endif

// ===== src/fsp_pkg.sv =====
package fsp_pkg;

    // Default sizes of the block.
    localparam int POS_WIDTH_DEF     = 24;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Fixed formats: Q0.16 offsets, Q30 rotation vector, 32-bit angle with a guard bit.
    localparam int OFS_WIDTH = 16;
    localparam int CW        = 34;
    localparam int ZW        = 33;

    // Gain-compensated start value of the rotation, 0.6072529350 in Q30.
    localparam logic signed [CW-1:0] KINV_Q30 = 34'sd652032875;

    // Distance limit after reset: 0.10 m in Q8.16.
    localparam int NEAR_DIST_RST = 6554;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_GOAL_X,
        REG_GOAL_Y,
        REG_GOAL_HEADING,
        REG_NEAR_DISTANCE,
        REG_NEAR_ANGLE
    } cfg_reg_t;

    // Pipeline control handed to every cell.
    typedef struct packed {
        logic en;
        logic valid;
    } cell_ctl_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [ZW-1:0] atan_q32(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:  a = 33'sd536870912;
            1:  a = 33'sd316933406;
            2:  a = 33'sd167458907;
            3:  a = 33'sd85004756;
            4:  a = 33'sd42667331;
            5:  a = 33'sd21354465;
            6:  a = 33'sd10679838;
            7:  a = 33'sd5340245;
            8:  a = 33'sd2670163;
            9:  a = 33'sd1335087;
            10: a = 33'sd667544;
            11: a = 33'sd333772;
            12: a = 33'sd166886;
            13: a = 33'sd83443;
            14: a = 33'sd41721;
            15: a = 33'sd20860;
            16: a = 33'sd10430;
            17: a = 33'sd5215;
            18: a = 33'sd2607;
            19: a = 33'sd1303;
            20: a = 33'sd651;
            21: a = 33'sd325;
            22: a = 33'sd162;
            23: a = 33'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== src/footstep_successor_pose.sv =====
// Footstep successor pose: rotates a Q0.16 step offset by the current heading, adds it to the
// Q8.16 foot position and reports step length, same-foot flag, distance to the goal and a
// near-goal flag. One transaction is accepted per clock cycle when the output side is not
// stalled; each transaction passes through the CORDIC cell chain, six arithmetic stages and the
// POS_WIDTH + 2 bit square-root cell chain. A stall on the result channel holds the whole
// pipeline. Goal registers must only be written while the block is idle.
`include "footstep_successor_pose_defines.svh"

module footstep_successor_pose #(
    parameter int POS_WIDTH     = fsp_pkg::POS_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = fsp_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = fsp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [2:0]                             cfg_index,
    input  logic [((POS_WIDTH > ANGLE_WIDTH) ? POS_WIDTH : ANGLE_WIDTH)-1:0] cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [POS_WIDTH-1:0]            s_cur_x,
    input  logic signed [POS_WIDTH-1:0]            s_cur_y,
    input  logic        [ANGLE_WIDTH-1:0]          s_cur_heading,
    input  logic                                   s_cur_foot,
    input  logic signed [fsp_pkg::OFS_WIDTH-1:0]   s_act_dx,
    input  logic signed [fsp_pkg::OFS_WIDTH-1:0]   s_act_dy,
    input  logic signed [ANGLE_WIDTH-1:0]          s_act_dturn,
    input  logic                                   s_act_foot,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [POS_WIDTH-1:0]            m_new_x,
    output logic signed [POS_WIDTH-1:0]            m_new_y,
    output logic        [ANGLE_WIDTH-1:0]          m_new_heading,
    output logic                                   m_new_foot,
    output logic        [POS_WIDTH-1:0]            m_step_cost,
    output logic                                   m_cost_infinite,
    output logic        [POS_WIDTH-1:0]            m_goal_distance,
    output logic                                   m_near_goal
);
    import fsp_pkg::*;

    localparam int P      = POS_WIDTH;
    localparam int A      = ANGLE_WIDTH;
    localparam int N      = CORDIC_STAGES;
    localparam int PW     = OFS_WIDTH + CW;
    localparam int TW     = P + 2;
    localparam int SW     = 2 * P + 3;
    localparam int VW     = SW + 1;
    localparam int R      = P + 2;
    localparam int SIDE_C = 1 + 2 * P + A + 2 + 2 * OFS_WIDTH;
    localparam int SIDE_Q = 2 * P + A + 5;
    localparam logic signed [TW-1:0] SAT_HI = TW'({1'b0, {(P-1){1'b1}}});
    localparam logic signed [TW-1:0] SAT_LO = ~SAT_HI;
    localparam logic [P-1:0]  POS_MAX  = {P{1'b1}};
    localparam logic [A-1:0]  NEAR_ANG_RST = A'(1) << (A - 3);

    // Configuration registers.
    logic signed [P-1:0] goal_x_reg, goal_y_reg;
    logic [A-1:0]        goal_heading_reg, near_angle_reg;
    logic [P-1:0]        near_distance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg        <= '0;
            goal_y_reg        <= '0;
            goal_heading_reg  <= '0;
            near_distance_reg <= P'(NEAR_DIST_RST);
            near_angle_reg    <= NEAR_ANG_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GOAL_X:        goal_x_reg        <= cfg_data[P-1:0];
                REG_GOAL_Y:        goal_y_reg        <= cfg_data[P-1:0];
                REG_GOAL_HEADING:  goal_heading_reg  <= cfg_data[A-1:0];
                REG_NEAR_DISTANCE: near_distance_reg <= cfg_data[P-1:0];
                REG_NEAR_ANGLE:    near_angle_reg    <= cfg_data[A-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a finished result waits.
    logic      m_valid_reg;
    logic      en;
    cell_ctl_t cctl [0:N];
    cell_ctl_t qctl [0:R];

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Entry: fold the heading into a quarter turn either side of zero.
    logic [31:0]          z32;
    logic                 fold;
    logic signed [ZW-1:0] z0;
    logic [A-1:0]         nh0;

    always_comb begin
        z32  = 32'(s_cur_heading) << (32 - A);
        fold = z32[31] ^ z32[30];
        z0   = ZW'($signed({fold ? ~z32[31] : z32[31], z32[30:0]}));
        nh0  = s_cur_heading + A'(s_act_dturn);
    end

    // CORDIC cell chain.
    logic signed [CW-1:0] cx_a [0:N];
    logic signed [CW-1:0] cy_a [0:N];
    logic signed [ZW-1:0] cz_a [0:N];
    logic [SIDE_C-1:0]    cs_a [0:N];
    logic                 cv_a [0:N];

    assign cx_a[0] = KINV_Q30;
    assign cy_a[0] = '0;
    assign cz_a[0] = z0;
    assign cs_a[0] = {fold, s_cur_x, s_cur_y, nh0, s_act_foot, s_cur_foot == s_act_foot,
                      s_act_dx, s_act_dy};
    assign cv_a[0] = s_valid;

    for (genvar k = 0; k < N; k++) begin : g_cordic
        assign cctl[k] = '{en: en, valid: cv_a[k]};
        fsp_cordic_cell #(.STAGE(k), .SIDE_W(SIDE_C)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (cctl[k]),
            .x_i     (cx_a[k]),
            .y_i     (cy_a[k]),
            .z_i     (cz_a[k]),
            .side_i  (cs_a[k]),
            .x_o     (cx_a[k+1]),
            .y_o     (cy_a[k+1]),
            .z_o     (cz_a[k+1]),
            .side_o  (cs_a[k+1]),
            .valid_o (cv_a[k+1])
        );
    end
    assign cctl[N] = '{en: en, valid: cv_a[N]};

    logic                    c_neg, c_af, c_inf;
    logic signed [P-1:0]     c_cx, c_cy;
    logic [A-1:0]            c_nh;
    logic signed [OFS_WIDTH-1:0] c_dx, c_dy;
    logic signed [CW-1:0]    c_cos, c_sin;

    assign {c_neg, c_cx, c_cy, c_nh, c_af, c_inf, c_dx, c_dy} = cs_a[N];
    assign c_cos = c_neg ? -cx_a[N] : cx_a[N];
    assign c_sin = c_neg ? -cy_a[N] : cy_a[N];

    // Products of the offset with cosine and sine.
    logic signed [PW-1:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic signed [P-1:0]  m1_cx_reg, m1_cy_reg;
    logic [A-1:0]         m1_nh_reg;
    logic                 m1_af_reg, m1_inf_reg, m1_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_xc_reg   <= PW'(c_dx) * PW'(c_cos);
            p_ys_reg   <= PW'(c_dy) * PW'(c_sin);
            p_xs_reg   <= PW'(c_dx) * PW'(c_sin);
            p_yc_reg   <= PW'(c_dy) * PW'(c_cos);
            m1_cx_reg  <= c_cx;
            m1_cy_reg  <= c_cy;
            m1_nh_reg  <= c_nh;
            m1_af_reg  <= c_af;
            m1_inf_reg <= c_inf;
        end
    end

    // Round the rotated offset, add it to the position and saturate.
    logic signed [PW:0]   sx, sy;
    logic signed [TW-1:0] tx, ty;
    logic signed [P-1:0]  nx_next, ny_next;

    always_comb begin
        sx = (PW+1)'(p_xc_reg) - (PW+1)'(p_ys_reg) + ((PW+1)'(1) <<< 29);
        sy = (PW+1)'(p_xs_reg) + (PW+1)'(p_yc_reg) + ((PW+1)'(1) <<< 29);
        tx = TW'(m1_cx_reg) + TW'(sx >>> 30);
        ty = TW'(m1_cy_reg) + TW'(sy >>> 30);
        if (tx > SAT_HI)      nx_next = SAT_HI[P-1:0];
        else if (tx < SAT_LO) nx_next = SAT_LO[P-1:0];
        else                  nx_next = tx[P-1:0];
        if (ty > SAT_HI)      ny_next = SAT_HI[P-1:0];
        else if (ty < SAT_LO) ny_next = SAT_LO[P-1:0];
        else                  ny_next = ty[P-1:0];
    end

    logic signed [P-1:0] m2_nx_reg, m2_ny_reg, m2_cx_reg, m2_cy_reg;
    logic [A-1:0]        m2_nh_reg;
    logic                m2_af_reg, m2_inf_reg, m2_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_nx_reg  <= nx_next;
            m2_ny_reg  <= ny_next;
            m2_cx_reg  <= m1_cx_reg;
            m2_cy_reg  <= m1_cy_reg;
            m2_nh_reg  <= m1_nh_reg;
            m2_af_reg  <= m1_af_reg;
            m2_inf_reg <= m1_inf_reg;
        end
    end

    // Coordinate differences as magnitudes, and the angle test.
    logic signed [P:0] d_cx, d_cy, d_gx, d_gy;
    logic [A-1:0]      ad, ad_abs;

    always_comb begin
        d_cx   = (P+1)'(m2_nx_reg) - (P+1)'(m2_cx_reg);
        d_cy   = (P+1)'(m2_ny_reg) - (P+1)'(m2_cy_reg);
        d_gx   = (P+1)'(m2_nx_reg) - (P+1)'(goal_x_reg);
        d_gy   = (P+1)'(m2_ny_reg) - (P+1)'(goal_y_reg);
        ad     = goal_heading_reg - m2_nh_reg;
        ad_abs = ad[A-1] ? -ad : ad;
    end

    logic [P:0]          mg_cx_reg, mg_cy_reg, mg_gx_reg, mg_gy_reg;
    logic signed [P-1:0] d_nx_reg, d_ny_reg;
    logic [A-1:0]        d_nh_reg;
    logic                d_af_reg, d_inf_reg, d_neara_reg, d_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mg_cx_reg   <= d_cx[P] ? -d_cx : d_cx;
            mg_cy_reg   <= d_cy[P] ? -d_cy : d_cy;
            mg_gx_reg   <= d_gx[P] ? -d_gx : d_gx;
            mg_gy_reg   <= d_gy[P] ? -d_gy : d_gy;
            d_nx_reg    <= m2_nx_reg;
            d_ny_reg    <= m2_ny_reg;
            d_nh_reg    <= m2_nh_reg;
            d_af_reg    <= m2_af_reg;
            d_inf_reg   <= m2_inf_reg;
            d_neara_reg <= ad_abs < near_angle_reg;
        end
    end

    // Squares.
    logic [2*P+1:0]      sq_cx_reg, sq_cy_reg, sq_gx_reg, sq_gy_reg;
    logic [2*P-1:0]      nd2_reg;
    logic signed [P-1:0] q_nx_reg, q_ny_reg;
    logic [A-1:0]        q_nh_reg;
    logic                q_af_reg, q_inf_reg, q_neara_reg, q_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_cx_reg   <= (2*P+2)'(mg_cx_reg) * (2*P+2)'(mg_cx_reg);
            sq_cy_reg   <= (2*P+2)'(mg_cy_reg) * (2*P+2)'(mg_cy_reg);
            sq_gx_reg   <= (2*P+2)'(mg_gx_reg) * (2*P+2)'(mg_gx_reg);
            sq_gy_reg   <= (2*P+2)'(mg_gy_reg) * (2*P+2)'(mg_gy_reg);
            nd2_reg     <= (2*P)'(near_distance_reg) * (2*P)'(near_distance_reg);
            q_nx_reg    <= d_nx_reg;
            q_ny_reg    <= d_ny_reg;
            q_nh_reg    <= d_nh_reg;
            q_af_reg    <= d_af_reg;
            q_inf_reg   <= d_inf_reg;
            q_neara_reg <= d_neara_reg;
        end
    end

    // Sums of squares; a sum that does not fit 64 bits saturates the distance.
    logic [SW-1:0] sum_c, sum_g;
    logic          ok_c, ok_g, near_next;

    always_comb begin
        sum_c     = SW'(sq_cx_reg) + SW'(sq_cy_reg);
        sum_g     = SW'(sq_gx_reg) + SW'(sq_gy_reg);
        ok_c      = (sum_c >> 64) == '0;
        ok_g      = (sum_g >> 64) == '0;
        near_next = ok_g && (sum_g < SW'(nd2_reg)) && q_neara_reg;
    end

    logic [SW-1:0]       s_sumc_reg, s_sumg_reg;
    logic signed [P-1:0] s_nx_reg, s_ny_reg;
    logic [A-1:0]        s_nh_reg;
    logic                s_af_reg, s_inf_reg, s_okc_reg, s_okg_reg, s_near_reg, s_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s_sumc_reg <= sum_c;
            s_sumg_reg <= sum_g;
            s_okc_reg  <= ok_c;
            s_okg_reg  <= ok_g;
            s_near_reg <= near_next;
            s_nx_reg   <= q_nx_reg;
            s_ny_reg   <= q_ny_reg;
            s_nh_reg   <= q_nh_reg;
            s_af_reg   <= q_af_reg;
            s_inf_reg  <= q_inf_reg;
        end
    end

    // Valid bits of the arithmetic stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            d_valid_reg  <= 1'b0;
            q_valid_reg  <= 1'b0;
            s_valid_reg  <= 1'b0;
        end else if (en) begin
            m1_valid_reg <= cctl[N].valid;
            m2_valid_reg <= m1_valid_reg;
            d_valid_reg  <= m2_valid_reg;
            q_valid_reg  <= d_valid_reg;
            s_valid_reg  <= q_valid_reg;
        end
    end

    // Square-root cell chain, step cost in lane 0 and goal distance in lane 1.
    logic [VW-1:0]     qv_a [0:R][2];
    logic [VW-1:0]     qr_a [0:R][2];
    logic [SIDE_Q-1:0] qs_a [0:R];
    logic              qval_a [0:R];

    assign qv_a[0][0] = VW'(s_sumc_reg);
    assign qv_a[0][1] = VW'(s_sumg_reg);
    assign qr_a[0][0] = '0;
    assign qr_a[0][1] = '0;
    assign qs_a[0]    = {s_nx_reg, s_ny_reg, s_nh_reg, s_af_reg, s_inf_reg,
                         s_okc_reg, s_okg_reg, s_near_reg};
    assign qval_a[0]  = s_valid_reg;

    for (genvar j = 0; j < R; j++) begin : g_sqrt
        assign qctl[j] = '{en: en, valid: qval_a[j]};
        fsp_sqrt_cell #(.BIT_IDX(R - 1 - j), .VW(VW), .SIDE_W(SIDE_Q)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (qctl[j]),
            .v_i     (qv_a[j]),
            .r_i     (qr_a[j]),
            .side_i  (qs_a[j]),
            .v_o     (qv_a[j+1]),
            .r_o     (qr_a[j+1]),
            .side_o  (qs_a[j+1]),
            .valid_o (qval_a[j+1])
        );
    end
    assign qctl[R] = '{en: en, valid: qval_a[R]};

    // Round the roots to nearest and saturate.
    logic signed [P-1:0] f_nx, f_ny;
    logic [A-1:0]        f_nh;
    logic                f_af, f_inf, f_okc, f_okg, f_near;
    logic [VW-1:0]       rnd_c, rnd_g;
    logic [P-1:0]        dist_c, dist_g;

    assign {f_nx, f_ny, f_nh, f_af, f_inf, f_okc, f_okg, f_near} = qs_a[R];

    always_comb begin
        rnd_c  = qr_a[R][0] + VW'(qv_a[R][0] > qr_a[R][0]);
        rnd_g  = qr_a[R][1] + VW'(qv_a[R][1] > qr_a[R][1]);
        dist_c = (!f_okc || rnd_c > VW'(POS_MAX)) ? POS_MAX : rnd_c[P-1:0];
        dist_g = (!f_okg || rnd_g > VW'(POS_MAX)) ? POS_MAX : rnd_g[P-1:0];
    end

    // Output register.
    logic signed [P-1:0] o_nx_reg, o_ny_reg;
    logic [A-1:0]        o_nh_reg;
    logic [P-1:0]        o_cost_reg, o_dist_reg;
    logic                o_af_reg, o_inf_reg, o_near_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= qctl[R].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_nx_reg   <= f_nx;
            o_ny_reg   <= f_ny;
            o_nh_reg   <= f_nh;
            o_af_reg   <= f_af;
            o_inf_reg  <= f_inf;
            o_cost_reg <= f_inf ? POS_MAX : dist_c;
            o_dist_reg <= dist_g;
            o_near_reg <= f_near;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_new_x         = o_nx_reg;
    assign m_new_y         = o_ny_reg;
    assign m_new_heading   = o_nh_reg;
    assign m_new_foot      = o_af_reg;
    assign m_step_cost     = o_cost_reg;
    assign m_cost_infinite = o_inf_reg;
    assign m_goal_distance = o_dist_reg;
    assign m_near_goal     = o_near_reg;

    // A same-foot transaction always carries the saturated cost.
    `FSP_ASSERT_IMP(a_inf_cost, m_valid && m_cost_infinite, m_step_cost == POS_MAX)
    // The rounded goal distance never exceeds the limit of a near result.
    `FSP_ASSERT_IMP(a_near_dist, m_valid && m_near_goal, m_goal_distance <= near_distance_reg)
    // No result is offered right after reset.
    `FSP_ASSERT_AFTER_RST(a_rst_empty, !m_valid && !m1_valid_reg && !s_valid_reg)
endmodule

// ===== src/fsp_cordic_cell.sv =====
module fsp_cordic_cell #(
    parameter int STAGE  = 0,
    parameter int SIDE_W = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fsp_pkg::cell_ctl_t                ctl,
    input  logic signed [fsp_pkg::CW-1:0]     x_i,
    input  logic signed [fsp_pkg::CW-1:0]     y_i,
    input  logic signed [fsp_pkg::ZW-1:0]     z_i,
    input  logic        [SIDE_W-1:0]          side_i,
    output logic signed [fsp_pkg::CW-1:0]     x_o,
    output logic signed [fsp_pkg::CW-1:0]     y_o,
    output logic signed [fsp_pkg::ZW-1:0]     z_o,
    output logic        [SIDE_W-1:0]          side_o,
    output logic                              valid_o
);
    import fsp_pkg::*;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [SIDE_W-1:0]    side_reg;
    logic                 valid_reg;

    // One micro-rotation toward zero residual angle.
    always_comb begin
        if (!z_i[ZW-1]) begin
            x_next = x_i - (y_i >>> STAGE);
            y_next = y_i + (x_i >>> STAGE);
            z_next = z_i - atan_q32(STAGE);
        end else begin
            x_next = x_i + (y_i >>> STAGE);
            y_next = y_i - (x_i >>> STAGE);
            z_next = z_i + atan_q32(STAGE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.en) begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_i;
        end
    end

    assign x_o     = x_reg;
    assign y_o     = y_reg;
    assign z_o     = z_reg;
    assign side_o  = side_reg;
    assign valid_o = valid_reg;
endmodule

// ===== src/fsp_sqrt_cell.sv =====
module fsp_sqrt_cell #(
    parameter int BIT_IDX = 0,
    parameter int VW      = 52,
    parameter int SIDE_W  = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fsp_pkg::cell_ctl_t ctl,
    input  logic [VW-1:0]      v_i [2],
    input  logic [VW-1:0]      r_i [2],
    input  logic [SIDE_W-1:0]  side_i,
    output logic [VW-1:0]      v_o [2],
    output logic [VW-1:0]      r_o [2],
    output logic [SIDE_W-1:0]  side_o,
    output logic               valid_o
);
    import fsp_pkg::*;

    localparam logic [VW-1:0] BIT_VAL = VW'(1) << (2 * BIT_IDX);

    logic [VW-1:0]     v_reg [2];
    logic [VW-1:0]     v_next [2];
    logic [VW-1:0]     r_reg [2];
    logic [VW-1:0]     r_next [2];
    logic [SIDE_W-1:0] side_reg;
    logic              valid_reg;

    // One result bit per lane: trial subtract of the partial root plus the bit weight.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (v_i[l] >= r_i[l] + BIT_VAL) begin
                v_next[l] = v_i[l] - (r_i[l] + BIT_VAL);
                r_next[l] = (r_i[l] >> 1) + BIT_VAL;
            end else begin
                v_next[l] = v_i[l];
                r_next[l] = r_i[l] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.en) begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            v_reg    <= v_next;
            r_reg    <= r_next;
            side_reg <= side_i;
        end
    end

    assign v_o     = v_reg;
    assign r_o     = r_reg;
    assign side_o  = side_reg;
    assign valid_o = valid_reg;
endmodule

// ===== tb/sv/tb_footstep_successor_pose.sv =====
`timescale 1ns / 1ps

module tb_footstep_successor_pose;
    import fsp_pkg::*;

    localparam int PW = 24;
    localparam int AW = 16;
    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + PW + 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint POS_MAX = (64'sd1 <<< (PW - 1)) - 1;
    localparam longint POS_MIN = -(64'sd1 <<< (PW - 1));
    localparam logic [63:0] POS_MASK = (64'd1 << PW) - 1;

    typedef struct packed {
        logic signed [PW-1:0] cur_x;
        logic signed [PW-1:0] cur_y;
        logic [AW-1:0]        cur_heading;
        logic                 cur_foot;
        logic signed [15:0]   act_dx;
        logic signed [15:0]   act_dy;
        logic signed [AW-1:0] act_dturn;
        logic                 act_foot;
    } step_req_t;

    typedef struct packed {
        logic signed [PW-1:0] new_x;
        logic signed [PW-1:0] new_y;
        logic [AW-1:0]        new_heading;
        logic                 new_foot;
        logic [PW-1:0]        step_cost;
        logic                 cost_infinite;
        logic [PW-1:0]        goal_distance;
        logic                 near_goal;
    } pose_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [PW-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    step_req_t req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pose_res_t res;

    // Local copy of the goal registers.
    logic signed [PW-1:0] goal_x_q = '0;
    logic signed [PW-1:0] goal_y_q = '0;
    logic [AW-1:0] goal_heading_q = '0;
    logic [PW-1:0] near_distance_q = PW'(NEAR_DIST_RST);
    logic [AW-1:0] near_angle_q = 16'd8192;

    pose_res_t expected_poses[$];
    int error_count = 0;
    int idle_cycles = 0;
    bit calm_mode = 1'b0;

    always #4 aclk = ~aclk;

    footstep_successor_pose dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cur_x(req.cur_x), .s_cur_y(req.cur_y), .s_cur_heading(req.cur_heading),
        .s_cur_foot(req.cur_foot), .s_act_dx(req.act_dx), .s_act_dy(req.act_dy),
        .s_act_dturn(req.act_dturn), .s_act_foot(req.act_foot),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_x(res.new_x), .m_new_y(res.new_y), .m_new_heading(res.new_heading),
        .m_new_foot(res.new_foot), .m_step_cost(res.step_cost),
        .m_cost_infinite(res.cost_infinite), .m_goal_distance(res.goal_distance),
        .m_near_goal(res.near_goal)
    );

    // Arithmetic shift right rounding toward minus infinity.
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    // Rotation vector of a heading: Q30 cosine and sine through the CORDIC iteration.
    function automatic void heading_vector(input logic [AW-1:0] hd,
                                           output longint c, output longint s);
        longint z, x, y, t;
        bit flip;
        longint atans[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81};
        z = longint'(hd) << (32 - AW);
        x = 652032875;
        y = 0;
        flip = 1'b0;
        if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
        if (z >= (64'sd1 <<< 30)) begin
            z -= (64'sd1 <<< 31);
            flip = 1'b1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z += (64'sd1 <<< 31);
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                t = x - shr_floor(y, i); y = y + shr_floor(x, i); x = t; z -= atans[i];
            end else begin
                t = x + shr_floor(y, i); y = y - shr_floor(x, i); x = t; z += atans[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint clamp_pos(longint v);
        return v > POS_MAX ? POS_MAX : (v < POS_MIN ? POS_MIN : v);
    endfunction

    // Squared length; offsets stay far below 2^32 so the sum never overflows 64 bits.
    function automatic logic [63:0] square_len(longint dx, longint dy);
        logic [63:0] ax, ay;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        return ax * ax + ay * ay;
    endfunction

    // Integer square root rounded to nearest, saturated to the position width.
    function automatic logic [63:0] rounded_root(logic [63:0] v);
        logic [63:0] r, b, rem;
        r = 0;
        b = 64'd1 << 62;
        rem = v;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (v - r * r > r) r++;
        return r > POS_MASK ? POS_MASK : r;
    endfunction

    function automatic pose_res_t successor_pose(step_req_t q);
        pose_res_t p;
        longint c, s, nx, ny, dh;
        logic [63:0] sq;
        heading_vector(q.cur_heading, c, s);
        nx = clamp_pos(longint'(q.cur_x) +
            shr_floor(longint'(q.act_dx) * c - longint'(q.act_dy) * s + (64'sd1 <<< 29), 30));
        ny = clamp_pos(longint'(q.cur_y) +
            shr_floor(longint'(q.act_dx) * s + longint'(q.act_dy) * c + (64'sd1 <<< 29), 30));
        p.new_x = PW'(nx);
        p.new_y = PW'(ny);
        p.new_heading = q.cur_heading + q.act_dturn;
        p.new_foot = q.act_foot;
        p.cost_infinite = (q.cur_foot == q.act_foot);
        p.step_cost = p.cost_infinite ? PW'(POS_MASK)
            : PW'(rounded_root(square_len(nx - q.cur_x, ny - q.cur_y)));
        sq = square_len(nx - goal_x_q, ny - goal_y_q);
        p.goal_distance = PW'(rounded_root(sq));
        dh = longint'($signed(AW'(goal_heading_q - p.new_heading)));
        if (dh < 0) dh = -dh;
        p.near_goal = (sq < 64'(near_distance_q) * 64'(near_distance_q))
            && (dh < longint'(near_angle_q));
        return p;
    endfunction

    // Result checking against the oldest expected pose.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            pose_res_t e;
            if (expected_poses.size() == 0) begin
                $error("unexpected result transaction");
                error_count++;
            end else begin
                e = expected_poses.pop_front();
                if (res.new_x !== e.new_x) begin
                    $error("new_x expected %0d got %0d", e.new_x, res.new_x); error_count++;
                end
                if (res.new_y !== e.new_y) begin
                    $error("new_y expected %0d got %0d", e.new_y, res.new_y); error_count++;
                end
                if (res.new_heading !== e.new_heading) begin
                    $error("new_heading expected %0d got %0d", e.new_heading, res.new_heading);
                    error_count++;
                end
                if (res.new_foot !== e.new_foot) begin
                    $error("new_foot expected %0d got %0d", e.new_foot, res.new_foot);
                    error_count++;
                end
                if (res.step_cost !== e.step_cost) begin
                    $error("step_cost expected %0d got %0d", e.step_cost, res.step_cost);
                    error_count++;
                end
                if (res.cost_infinite !== e.cost_infinite) begin
                    $error("cost_infinite expected %0d got %0d", e.cost_infinite,
                           res.cost_infinite);
                    error_count++;
                end
                if (res.goal_distance !== e.goal_distance) begin
                    $error("goal_distance expected %0d got %0d", e.goal_distance,
                           res.goal_distance);
                    error_count++;
                end
                if (res.near_goal !== e.near_goal) begin
                    $error("near_goal expected %0d got %0d", e.near_goal, res.near_goal);
                    error_count++;
                end
            end
        end
    end

    // Receiver stalls at random unless in a calm stretch.
    always @(posedge aclk) begin
        m_ready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 18);
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Valid drops only for idle cycles, so back-to-back transactions keep it high.
    task automatic send_step(step_req_t q);
        if (!calm_mode) begin
            while ($urandom_range(99) < 18) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        req <= q;
        do @(posedge aclk); while (!s_ready);
        expected_poses.insert(expected_poses.size(), successor_pose(q));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [PW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            REG_GOAL_X:        goal_x_q = val;
            REG_GOAL_Y:        goal_y_q = val;
            REG_GOAL_HEADING:  goal_heading_q = val[AW-1:0];
            REG_NEAR_DISTANCE: near_distance_q = val;
            REG_NEAR_ANGLE:    near_angle_q = val[AW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_goal(logic [PW-1:0] gx, logic [PW-1:0] gy, logic [AW-1:0] gh,
                            logic [PW-1:0] nd, logic [AW-1:0] na);
        drain_results();
        write_reg(REG_GOAL_X, gx);
        write_reg(REG_GOAL_Y, gy);
        write_reg(REG_GOAL_HEADING, PW'(gh));
        write_reg(REG_NEAR_DISTANCE, nd);
        write_reg(REG_NEAR_ANGLE, PW'(na));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic step_req_t make_step(longint x, longint y, int hd, bit cf,
                                            int dx, int dy, int dt, bit af);
        step_req_t q;
        q.cur_x = PW'(x); q.cur_y = PW'(y); q.cur_heading = AW'(hd); q.cur_foot = cf;
        q.act_dx = 16'(dx); q.act_dy = 16'(dy); q.act_dturn = AW'(dt); q.act_foot = af;
        return q;
    endfunction

    // Field extremes, saturation, same foot, quarter-turn headings and goal hits.
    task automatic test_directed();
        int heads[8] = '{0, 16384, 32768, 49152, 65535, 16383, 32767, 8192};
        for (int i = 0; i < 8; i++)
            send_step(make_step(0, 0, heads[i], 0, 16000, -12000, 100, 1));
        send_step(make_step(POS_MAX, POS_MAX, 0, 0, 32767, 32767, 32767, 1));
        send_step(make_step(POS_MIN, POS_MIN, 32768, 1, -32768, -32768, -32768, 0));
        send_step(make_step(POS_MAX, POS_MIN, 16384, 1, 32767, -32768, 0, 1));
        send_step(make_step(0, 0, 0, 1, 0, 0, 0, 1));
        send_step(make_step(100, -100, 0, 0, 1000, 1000, 0, 0));
        send_step(make_step(-3000, 2000, 0, 1, 3000, 0, 0, 0));
        send_step(make_step(0, 0, 65535, 0, -1, -1, 1, 1));
        send_step(make_step(POS_MIN, POS_MAX, 49152, 0, -32768, 32767, -1, 1));
        // Exactly a half-turn off the goal heading.
        send_step(make_step(0, 0, 0, 0, 0, 0, -32768, 1));
        send_step(make_step(0, 0, 8191, 0, 0, 0, 0, 1));
        send_step(make_step(0, 0, 8192, 0, 0, 0, 0, 1));
    endtask

    function automatic step_req_t random_step(bit near_goal_bias);
        step_req_t q;
        q.cur_x = near_goal_bias ? PW'(goal_x_q + $signed(PW'($urandom_range(8000))) - 4000)
                                 : PW'($urandom);
        q.cur_y = near_goal_bias ? PW'(goal_y_q + $signed(PW'($urandom_range(8000))) - 4000)
                                 : PW'($urandom);
        q.cur_heading = AW'($urandom);
        q.cur_foot = 1'($urandom_range(1));
        q.act_dx = near_goal_bias ? 16'($signed(17'($urandom_range(4000))) - 2000)
                                  : 16'($urandom);
        q.act_dy = near_goal_bias ? 16'($signed(17'($urandom_range(4000))) - 2000)
                                  : 16'($urandom);
        q.act_dturn = AW'($urandom);
        q.act_foot = ($urandom_range(99) < 80) ? ~q.cur_foot : q.cur_foot;
        return q;
    endfunction

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 3) calm_mode = 1'b1;
            if (i == count / 3 + 60) calm_mode = 1'b0;
            send_step(random_step($urandom_range(99) < 40));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        set_goal(PW'(20000), PW'(-15000), 16'd40000, PW'(30000), 16'd16000);
        test_random(110);
        set_goal(PW'(POS_MAX), PW'(POS_MIN), 16'd65535, PW'(POS_MASK), 16'd32768);
        test_random(110);
        set_goal(PW'(POS_MIN), PW'(POS_MAX), 16'd0, PW'(0), 16'd0);
        test_random(60);
        set_goal(PW'(-500), PW'(700), 16'd12345, PW'(6554), 16'd8192);
        test_random(170);
        drain_results();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/fsp_pkg.sv
src/fsp_cordic_cell.sv
src/fsp_sqrt_cell.sv
src/footstep_successor_pose.sv
tb/sv/tb_footstep_successor_pose.sv
